[hw/rtl/mstb_pkg.sv]
// shared types and constants for the soft timer bank
// no dependencies

package mstb_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic [2:0] KIND_TICK       = 3'd0;
  localparam logic [2:0] KIND_START_ONCE = 3'd1;
  localparam logic [2:0] KIND_START_AUTO = 3'd2;
  localparam logic [2:0] KIND_STOP       = 3'd3;
  localparam logic [2:0] KIND_CHECK      = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  timer_id;
    logic [31:0] period;
  } in_item_t;

  typedef struct packed {
    logic expired;
    logic status;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic dispatch;
    logic walk_rd;
    logic exec;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic cmd_ok;
    logic walk_last;
  } dp_sts_t;

endpackage

[hw/rtl/multi_channel_soft_timer_bank_core.sv]
// Bank of NUM_TIMERS down-counting timers with one-shot and auto-reload modes.
// Each transaction (tick, start, stop or check) returns exactly one result
// transaction. Start, stop and check transactions pass the dispatch, command
// and done states; ignored transactions (bad timer id or undefined kind) skip
// the command state. A tick walks the bank one timer per cycle through the
// read port of the count and reload rams. A new transaction is accepted while
// the previous result still waits in the output register.
// depends on mstb_pkg, mstb_ctrl, mstb_datapath

module multi_channel_soft_timer_bank_core import mstb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  mstb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mstb_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

[hw/rtl/mstb_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies

module mstb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/mstb_datapath.sv]
// timer bank datapath: count and reload rams, flags, modes, walk index, result
// depends on mstb_pkg and mstb_ram

module mstb_datapath import mstb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  ctrl_cmd_t cmd,
  output dp_sts_t   sts,
  output out_item_t out_data
);

  in_item_t               item_r;
  logic [IDX_W-1:0]       walk_idx_r, walk_idx_nxt;
  logic [IDX_W-1:0]       wb_idx_r;
  logic                   wb_vld_r, wb_vld_nxt;
  logic [NUM_TIMERS-1:0]  cnt_vld_r, cnt_vld_nxt;
  logic [NUM_TIMERS-1:0]  rld_vld_r, rld_vld_nxt;
  logic [NUM_TIMERS-1:0]  flag_r, flag_nxt;
  logic [NUM_TIMERS-1:0]  auto_r, auto_nxt;
  out_item_t              res_r, res_nxt;
  out_item_t              out_data_r;

  logic [COUNT_WIDTH-1:0] cnt_rdata, rld_rdata;
  logic [COUNT_WIDTH-1:0] cnt_cur, rld_cur, cnt_dec, cnt_new;
  logic [COUNT_WIDTH-1:0] per;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic [IDX_W-1:0]       cnt_waddr, cidx;
  logic                   cnt_we, rld_we;
  logic                   tick_wr, fire;
  logic                   is_start, is_stop, is_check, is_cmd, id_ok;

  assign cidx     = item_r.timer_id[IDX_W-1:0];
  assign per      = item_r.period[COUNT_WIDTH-1:0];
  assign is_start = (item_r.kind == KIND_START_ONCE) || (item_r.kind == KIND_START_AUTO);
  assign is_stop  = (item_r.kind == KIND_STOP);
  assign is_check = (item_r.kind == KIND_CHECK);
  assign is_cmd   = is_start || is_stop || is_check;
  assign id_ok    = ({1'b0, item_r.timer_id} < 9'(NUM_TIMERS));

  assign sts.is_tick   = (item_r.kind == KIND_TICK);
  assign sts.cmd_ok    = is_cmd && id_ok;
  assign sts.walk_last = (walk_idx_r == IDX_W'(NUM_TIMERS - 1));

  // tick writeback for the entry read in the previous cycle
  assign cnt_cur = cnt_vld_r[wb_idx_r] ? cnt_rdata : '0;
  assign rld_cur = rld_vld_r[wb_idx_r] ? rld_rdata : '0;
  assign cnt_dec = cnt_cur - COUNT_WIDTH'(1);
  assign tick_wr = wb_vld_r && (cnt_cur != '0);
  assign fire    = tick_wr && (cnt_dec == '0);

  always_comb begin
    cnt_new = cnt_dec;
    if (cnt_dec == '0) begin
      cnt_new = auto_r[wb_idx_r] ? rld_cur : '0;
    end
  end

  always_comb begin
    cnt_we    = tick_wr;
    cnt_waddr = wb_idx_r;
    cnt_wdata = cnt_new;
    rld_we    = 1'b0;
    if (cmd.exec && is_start) begin
      cnt_we    = 1'b1;
      cnt_waddr = cidx;
      cnt_wdata = per;
      rld_we    = 1'b1;
    end else if (cmd.exec && is_stop) begin
      cnt_we    = 1'b1;
      cnt_waddr = cidx;
      cnt_wdata = '0;
    end
  end

  mstb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_TIMERS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cmd.walk_rd),
    .raddr (walk_idx_r),
    .rdata (cnt_rdata)
  );

  mstb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_TIMERS)) u_rld_ram (
    .clk   (clk),
    .we    (rld_we),
    .waddr (cidx),
    .wdata (per),
    .re    (cmd.walk_rd),
    .raddr (walk_idx_r),
    .rdata (rld_rdata)
  );

  always_comb begin
    walk_idx_nxt = walk_idx_r;
    wb_vld_nxt   = cmd.walk_rd;
    cnt_vld_nxt  = cnt_vld_r;
    rld_vld_nxt  = rld_vld_r;
    flag_nxt     = flag_r;
    auto_nxt     = auto_r;
    res_nxt      = res_r;
    if (cmd.accept) begin
      walk_idx_nxt = '0;
    end else if (cmd.walk_rd) begin
      walk_idx_nxt = walk_idx_r + IDX_W'(1);
    end
    if (fire) begin
      flag_nxt[wb_idx_r] = 1'b1;
    end
    if (cmd.dispatch) begin
      res_nxt.expired = 1'b0;
      res_nxt.status  = is_cmd && !id_ok;
    end
    if (cmd.exec) begin
      if (is_start) begin
        cnt_vld_nxt[cidx] = 1'b1;
        rld_vld_nxt[cidx] = 1'b1;
        flag_nxt[cidx]    = 1'b0;
        auto_nxt[cidx]    = (item_r.kind == KIND_START_AUTO);
      end else if (is_stop) begin
        cnt_vld_nxt[cidx] = 1'b1;
        flag_nxt[cidx]    = 1'b0;
        auto_nxt[cidx]    = 1'b0;
      end else if (is_check) begin
        res_nxt.expired = flag_r[cidx];
        flag_nxt[cidx]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_idx_r <= '0;
      wb_vld_r   <= 1'b0;
      cnt_vld_r  <= '0;
      rld_vld_r  <= '0;
      flag_r     <= '0;
      auto_r     <= '0;
    end else begin
      walk_idx_r <= walk_idx_nxt;
      wb_vld_r   <= wb_vld_nxt;
      cnt_vld_r  <= cnt_vld_nxt;
      rld_vld_r  <= rld_vld_nxt;
      flag_r     <= flag_nxt;
      auto_r     <= auto_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_idx_r <= walk_idx_r;
    res_r    <= res_nxt;
    if (cmd.accept) begin
      item_r <= in_data;
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_data = out_data_r;

endmodule

[hw/rtl/mstb_ctrl.sv]
// timer bank controller: item sequencing, bank walk and output handshake
// depends on mstb_pkg

module mstb_ctrl import mstb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_WALK     = 6'b000100,
    S_WALK_END = 6'b001000,
    S_CMD      = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.accept   = in_valid && in_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        if (sts.is_tick) begin
          state_nxt = S_WALK;
        end else if (sts.cmd_ok) begin
          state_nxt = S_CMD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WALK: begin
        cmd.walk_rd = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_WALK_END;
        end
      end
      S_WALK_END: begin
        state_nxt = S_DONE;
      end
      S_CMD: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_walk_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && !sts.walk_last) |=> (state_r == S_WALK))
    else $error("bank walk ended early");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("result left while output register full");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISPATCH))
    else $error("accepted transaction not dispatched");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

endmodule

[bench/tb.sv]
// self-checking testbench for multi_channel_soft_timer_bank_core
// predicts every result transaction from a cycle-free model of the timer bank
// depends on mstb_pkg and the core rtl

module tb;
  import mstb_pkg::*;

  localparam int STIM_PER_PHASE = 350;
  localparam int MAX_RUN        = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  class timer_bank_scoreboard;
    logic [COUNT_WIDTH-1:0] count_q  [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] reload_q [NUM_TIMERS];
    bit                     fired    [NUM_TIMERS];
    bit                     reloads  [NUM_TIMERS];
    out_item_t              expected_results[$];
    int unsigned            fail_count;

    function new();
      for (int t = 0; t < NUM_TIMERS; t++) begin
        count_q[t]  = '0;
        reload_q[t] = '0;
        fired[t]    = 1'b0;
        reloads[t]  = 1'b0;
      end
      fail_count = 0;
    endfunction

    function void record_request(in_item_t req);
      out_item_t res;
      int        t;
      res = '0;
      t   = int'(req.timer_id);
      case (req.kind)
        KIND_TICK: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (count_q[i] != '0) begin
              count_q[i] = count_q[i] - 1'b1;
              if (count_q[i] == '0) begin
                fired[i] = 1'b1;
                if (reloads[i]) count_q[i] = reload_q[i];
              end
            end
          end
        end
        KIND_START_ONCE, KIND_START_AUTO, KIND_STOP, KIND_CHECK: begin
          if (t >= NUM_TIMERS) begin
            res.status = 1'b1;
          end else if (req.kind == KIND_STOP) begin
            count_q[t] = '0;
            fired[t]   = 1'b0;
            reloads[t] = 1'b0;
          end else if (req.kind == KIND_CHECK) begin
            res.expired = fired[t];
            fired[t]    = 1'b0;
          end else begin
            count_q[t]  = req.period[COUNT_WIDTH-1:0];
            reload_q[t] = req.period[COUNT_WIDTH-1:0];
            fired[t]    = 1'b0;
            reloads[t]  = (req.kind == KIND_START_AUTO);
          end
        end
        default: ;
      endcase
      expected_results.push_back(res);
    endfunction

    function void check_response(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $error("result transaction with none expected: expired %0b status %0b",
               got.expired, got.status);
        fail_count++;
        return;
      end
      want = expected_results.pop_front();
      if (got.expired !== want.expired) begin
        $error("expired: expected %0b, got %0b", want.expired, got.expired);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0b, got %0b", want.status, got.status);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  timer_bank_scoreboard sb = new();
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  pressure_req   = 1'b0;
  int  idle_cycles    = 0;

  multi_channel_soft_timer_bank_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // both channels sampled at the edge, before this edge's updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_response(out_data);
      if (in_valid && in_ready) sb.record_request(in_data);
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int stall_run;
    stall_run = 0;
    forever begin
      @(posedge clk);
      if (pressure_req) begin
        pressure_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (recv_stall_pct > 0 && stall_run < MAX_RUN &&
                   $urandom_range(99) < recv_stall_pct) begin
        out_ready <= 1'b0;
        stall_run++;
      end else begin
        out_ready <= 1'b1;
        stall_run = 0;
      end
    end
  end

  task automatic send_item(input in_item_t req);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && gap < MAX_RUN && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_op(input logic [2:0] kind, input logic [7:0] id,
                         input logic [31:0] period);
    in_item_t req;
    req.kind     = kind;
    req.timer_id = id;
    req.period   = period;
    send_item(req);
  endtask

  function automatic in_item_t random_item();
    in_item_t req;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 35)      req.kind = KIND_TICK;
    else if (pick < 50) req.kind = KIND_START_ONCE;
    else if (pick < 65) req.kind = KIND_START_AUTO;
    else if (pick < 73) req.kind = KIND_STOP;
    else if (pick < 95) req.kind = KIND_CHECK;
    else                req.kind = 3'($urandom_range(7, 5));
    if ($urandom_range(99) < 8) req.timer_id = 8'($urandom_range(255, NUM_TIMERS));
    else                        req.timer_id = 8'($urandom_range(NUM_TIMERS - 1));
    if ($urandom_range(99) < 10) req.period = $urandom();
    else                         req.period = 32'($urandom_range(8));
    return req;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fields at their extremes, every kind, special cases
    send_op(KIND_TICK,       8'hFF, 32'hFFFF_FFFF);
    send_op(KIND_CHECK,      8'd0,  32'd0);
    send_op(KIND_START_ONCE, 8'd0,  32'd1);
    send_op(KIND_TICK,       8'd0,  32'd0);
    send_op(KIND_CHECK,      8'd0,  32'd0);
    send_op(KIND_CHECK,      8'd0,  32'd0);
    send_op(KIND_START_AUTO, 8'd1,  32'd2);
    repeat (4) send_op(KIND_TICK, 8'd0, 32'd0);
    send_op(KIND_CHECK,      8'd1,  32'd0);
    send_op(KIND_START_ONCE, 8'd2,  32'd0);
    send_op(KIND_START_AUTO, 8'd6,  32'd0);
    send_op(KIND_TICK,       8'd0,  32'd0);
    send_op(KIND_CHECK,      8'd2,  32'd0);
    send_op(KIND_START_ONCE, 8'd3,  32'hFFFF_FFFF);
    send_op(KIND_STOP,       8'd1,  32'd0);
    send_op(KIND_START_ONCE, 8'd4,  32'd1);
    send_op(KIND_TICK,       8'd0,  32'd0);
    send_op(KIND_STOP,       8'd4,  32'd0);
    send_op(KIND_CHECK,      8'd4,  32'd0);
    send_op(KIND_START_ONCE, 8'd8,  32'd5);
    send_op(KIND_STOP,       8'hFF, 32'd0);
    send_op(KIND_CHECK,      8'h80, 32'd0);
    send_op(3'd5,            8'd0,  32'd1);
    send_op(3'd6,            8'd7,  32'hAAAA_5555);
    send_op(3'd7,            8'd0,  32'd1);
    send_op(KIND_START_AUTO, 8'd7,  32'h8000_0000);
    send_op(KIND_CHECK,      8'd7,  32'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int i = 0; i < STIM_PER_PHASE; i++) begin
        if (phase == 0 && i == 20) pressure_req = 1'b1;
        send_item(random_item());
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (NUM_TIMERS + 8) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
